/* design/tcc_pkg.sv */
`default_nettype none
package tcc_pkg;

	localparam int COLS       = 80;
	localparam int ROWS       = 25;
	localparam int CELL_COUNT = ROWS * COLS;
	localparam int COPY_COUNT = (ROWS - 1) * COLS;

	localparam int ADDR_W = 11;
	localparam int ROW_W  = 5;
	localparam int COL_W  = 7;
	localparam int CELL_W = 16;

	localparam logic [7:0] NEWLINE_CODE = 8'd10;
	localparam logic [7:0] BLANK_CODE   = 8'd32;

	localparam logic [3:0] FG_RESET = 4'h7;
	localparam logic [3:0] BG_RESET = 4'h0;

	localparam logic [1:0] OP_PUT = 2'd0;
	localparam logic [1:0] OP_CLR = 2'd1;
	localparam logic [1:0] OP_RD  = 2'd2;

	localparam logic CFG_FG = 1'b0;
	localparam logic CFG_BG = 1'b1;

	typedef enum logic [1:0] {
		CUR_HOLD,
		CUR_PUT,
		CUR_HOME
	} cur_op_t;

	typedef enum logic [1:0] {
		MEM_NONE,
		MEM_PUT,
		MEM_COPY,
		MEM_FILL
	} mem_op_t;

	typedef struct packed {
		logic    load;
		cur_op_t cur_op;
		mem_op_t mem_op;
		logic    rd_idx;
		logic    ptr_clr;
		logic    ptr_inc;
		logic    emit;
		logic    emit_scr;
		logic    emit_rd;
	} tcc_cmd_t;

	typedef struct packed {
		logic [1:0] op;
		logic       is_nl;
		logic       need_scroll;
		logic       copy_last;
		logic       cell_last;
	} tcc_sts_t;

endpackage
`default_nettype wire

/* design/tcc_ctrl.sv */
`default_nettype none
module tcc_ctrl import tcc_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     start,
	output logic          busy,
	input  tcc_sts_t      sts,
	output tcc_cmd_t      cmd
);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_EXEC   = 3'd1;
	localparam logic [2:0] S_RDWAIT = 3'd2;
	localparam logic [2:0] S_COPY   = 3'd3;
	localparam logic [2:0] S_DRAIN  = 3'd4;
	localparam logic [2:0] S_FILL   = 3'd5;
	localparam logic [2:0] S_CLEAR  = 3'd6;

	logic [2:0] state_q;
	logic [2:0] state_d;

	assign busy = (state_q != S_IDLE);

	always_comb begin
		cmd     = '0;
		cmd.cur_op = CUR_HOLD;
		cmd.mem_op = MEM_NONE;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = S_EXEC;
				end
			end
			S_EXEC: begin
				unique case (sts.op)
					OP_PUT: begin
						cmd.cur_op = CUR_PUT;
						cmd.mem_op = sts.is_nl ? MEM_NONE : MEM_PUT;
						if (sts.need_scroll) begin
							cmd.ptr_clr = 1'b1;
							state_d     = S_COPY;
						end else begin
							cmd.emit = 1'b1;
							state_d  = S_IDLE;
						end
					end
					OP_CLR: begin
						cmd.cur_op  = CUR_HOME;
						cmd.ptr_clr = 1'b1;
						state_d     = S_CLEAR;
					end
					OP_RD: begin
						cmd.rd_idx = 1'b1;
						state_d    = S_RDWAIT;
					end
					default: begin
						cmd.emit = 1'b1;
						state_d  = S_IDLE;
					end
				endcase
			end
			S_RDWAIT: begin
				cmd.emit    = 1'b1;
				cmd.emit_rd = 1'b1;
				state_d     = S_IDLE;
			end
			S_COPY: begin
				cmd.mem_op  = MEM_COPY;
				cmd.ptr_inc = 1'b1;
				if (sts.copy_last) begin
					state_d = S_DRAIN;
				end
			end
			S_DRAIN: begin
				state_d = S_FILL;
			end
			S_FILL: begin
				cmd.mem_op  = MEM_FILL;
				cmd.ptr_inc = 1'b1;
				if (sts.cell_last) begin
					cmd.emit     = 1'b1;
					cmd.emit_scr = 1'b1;
					state_d      = S_IDLE;
				end
			end
			S_CLEAR: begin
				cmd.mem_op  = MEM_FILL;
				cmd.ptr_inc = 1'b1;
				if (sts.cell_last) begin
					cmd.emit = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule
`default_nettype wire

/* design/tcc_dp.sv */
`default_nettype none
module tcc_dp import tcc_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  tcc_cmd_t               cmd,
	output tcc_sts_t               sts,
	input  wire logic [1:0]        in_cmd,
	input  wire logic [7:0]        in_char,
	input  wire logic [ADDR_W-1:0] in_idx,
	input  wire logic              cfg_we,
	input  wire logic              cfg_sel,
	input  wire logic [3:0]        cfg_data,
	output logic                   done,
	output logic [ROW_W-1:0]       cursor_row,
	output logic [COL_W-1:0]       cursor_col,
	output logic                   scrolled,
	output logic [CELL_W-1:0]      cell_value
);

	logic [CELL_W-1:0] mem [CELL_COUNT];

	logic [1:0]        op_q;
	logic [7:0]        char_q;
	logic [ADDR_W-1:0] idx_q;
	logic [3:0]        fg_q;
	logic [3:0]        bg_q;
	logic [ROW_W-1:0]  row_q;
	logic [COL_W-1:0]  col_q;
	logic [ADDR_W-1:0] ptr_q;
	logic              cp_vld_s1;
	logic [ADDR_W-1:0] cp_addr_s1;
	logic [CELL_W-1:0] rdata_q;
	logic              idx_ok_q;

	logic [ROW_W:0]    row_inc;
	logic [COL_W:0]    col_inc;
	logic [ROW_W-1:0]  row_put;
	logic [COL_W-1:0]  col_put;
	logic              wrap;
	logic [ROW_W-1:0]  row_nx;
	logic [COL_W-1:0]  col_nx;
	logic [ADDR_W-1:0] pos;
	logic [ADDR_W-1:0] raddr;
	logic [7:0]        attr;

	assign attr = {bg_q, fg_q};
	assign pos  = ADDR_W'(row_q) * ADDR_W'(COLS) + ADDR_W'(col_q);

	assign row_inc = {1'b0, row_q} + (ROW_W + 1)'(1);
	assign col_inc = {1'b0, col_q} + (COL_W + 1)'(1);
	assign wrap    = (char_q == NEWLINE_CODE) || (col_inc >= (COL_W + 1)'(COLS));

	always_comb begin
		if (wrap) begin
			col_put = '0;
			if (row_inc >= (ROW_W + 1)'(ROWS)) begin
				row_put = ROW_W'(ROWS - 1);
			end else begin
				row_put = row_inc[ROW_W-1:0];
			end
		end else begin
			col_put = col_inc[COL_W-1:0];
			row_put = row_q;
		end
	end

	always_comb begin
		unique case (cmd.cur_op)
			CUR_PUT: begin
				row_nx = row_put;
				col_nx = col_put;
			end
			CUR_HOME: begin
				row_nx = '0;
				col_nx = '0;
			end
			default: begin
				row_nx = row_q;
				col_nx = col_q;
			end
		endcase
	end

	assign sts.op          = op_q;
	assign sts.is_nl       = (char_q == NEWLINE_CODE);
	assign sts.need_scroll = wrap && (row_inc >= (ROW_W + 1)'(ROWS));
	assign sts.copy_last   = (ptr_q == ADDR_W'(COPY_COUNT - 1));
	assign sts.cell_last   = (ptr_q == ADDR_W'(CELL_COUNT - 1));

	assign raddr = cmd.rd_idx ? idx_q : ptr_q + ADDR_W'(COLS);

	always_ff @(posedge clk) begin
		rdata_q <= mem[raddr];
		if (cp_vld_s1) begin
			mem[cp_addr_s1] <= rdata_q;
		end else if (cmd.mem_op == MEM_PUT) begin
			mem[pos] <= {attr, char_q};
		end else if (cmd.mem_op == MEM_FILL) begin
			mem[ptr_q] <= {attr, BLANK_CODE};
		end
	end

	always_ff @(posedge clk) begin
		cp_addr_s1 <= ptr_q;
		if (cmd.load) begin
			op_q   <= in_cmd;
			char_q <= in_char;
			idx_q  <= in_idx;
		end
		if (cmd.rd_idx) begin
			idx_ok_q <= (idx_q < ADDR_W'(CELL_COUNT));
		end
		if (cmd.emit) begin
			cursor_row <= row_nx;
			cursor_col <= col_nx;
			scrolled   <= cmd.emit_scr;
			cell_value <= (cmd.emit_rd && idx_ok_q) ? rdata_q : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fg_q      <= FG_RESET;
			bg_q      <= BG_RESET;
			row_q     <= '0;
			col_q     <= '0;
			ptr_q     <= '0;
			cp_vld_s1 <= 1'b0;
			done      <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_sel)
					CFG_FG: fg_q <= cfg_data;
					CFG_BG: bg_q <= cfg_data;
					default: fg_q <= fg_q;
				endcase
			end
			row_q     <= row_nx;
			col_q     <= col_nx;
			cp_vld_s1 <= (cmd.mem_op == MEM_COPY);
			done      <= cmd.emit;
			if (cmd.ptr_clr) begin
				ptr_q <= '0;
			end else if (cmd.ptr_inc) begin
				ptr_q <= ptr_q + ADDR_W'(1);
			end
		end
	end

endmodule
`default_nettype wire

/* design/text_console_cursor_scroll_top.sv */
`default_nettype none
// text console, 80 by 25 cells of {attribute, character}, with a cursor
// command channel: an item transfers when start is high and busy is low;
//   cmd 0 puts char_code at the cursor (newline moves to the next row),
//   cmd 1 clears the screen with blanks and homes the cursor,
//   cmd 2 reads the cell at cell_index into cell_value
// result: done pulses for one cycle with cursor_row, cursor_col, scrolled
//   and cell_value; the receiver cannot stall, so each result is offered once
// path from transfer to done:
//   put without scroll and unused codes: the execute state, then done
//   read: execute, then a wait state (registered cell buffer read port)
//   put with scroll: the buffer walk moves 1920 cells through
//   one read and one write port, then writes 80 blanks into the last row
//   clear: one blank cell write per cycle
// busy stays high until done, so a new item can transfer in the done cycle
// config channel: cfg_valid/cfg_ready, cfg_index 0 fg_color, 1 bg_color,
//   always ready; user must ensure it is written only while the block is idle
// reset: cursor home, fg_color 7, bg_color 0; buffer contents undefined
//   until the first clear
module text_console_cursor_scroll_top import tcc_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	output logic                   busy,
	input  wire logic [1:0]        cmd,
	input  wire logic [7:0]        char_code,
	input  wire logic [ADDR_W-1:0] cell_index,
	input  wire logic              cfg_valid,
	output logic                   cfg_ready,
	input  wire logic              cfg_index,
	input  wire logic [3:0]        cfg_data,
	output logic                   done,
	output logic [ROW_W-1:0]       cursor_row,
	output logic [COL_W-1:0]       cursor_col,
	output logic                   scrolled,
	output logic [CELL_W-1:0]      cell_value
);

	tcc_cmd_t ctl_cmd;
	tcc_sts_t ctl_sts;

	assign cfg_ready = 1'b1;

	tcc_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.sts    (ctl_sts),
		.cmd    (ctl_cmd)
	);

	tcc_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (ctl_cmd),
		.sts        (ctl_sts),
		.in_cmd     (cmd),
		.in_char    (char_code),
		.in_idx     (cell_index),
		.cfg_we     (cfg_valid & cfg_ready),
		.cfg_sel    (cfg_index),
		.cfg_data   (cfg_data),
		.done       (done),
		.cursor_row (cursor_row),
		.cursor_col (cursor_col),
		.scrolled   (scrolled),
		.cell_value (cell_value)
	);

endmodule
`default_nettype wire
